// File: rtl/core/ptq_pkg.sv
package ptq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int PRIO_W = 10;
    localparam int HANDLE_W = 8;
    localparam int COUNT_OUT_W = 5;

    localparam logic [PRIO_W-1:0] RESET_IDLE_PRIORITY = 10'd999;

    // Register map (byte addresses).
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_IDLE_PRIORITY = 3'd0;

    localparam logic [1:0] MODE_ENQUEUE  = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_DONE     = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_INSERT     = 2'd1;
    localparam logic [1:0] CELL_POP        = 2'd2;
    localparam logic [1:0] CELL_INSERT_POP = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HANDLE_W-1:0] task_handle;
        logic [PRIO_W-1:0]   task_priority;
    } t_cmd;

    typedef struct packed {
        logic [1:0]             status;
        logic                   dispatch_valid;
        logic [HANDLE_W-1:0]    dispatched_handle;
        logic [PRIO_W-1:0]      dispatched_priority;
        logic [COUNT_OUT_W-1:0] queue_count;
    } t_result;

    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
    } t_slot;

    typedef struct packed {
        logic [1:0] op;
        t_slot      new_slot;
    } t_cell_ctl;

endpackage

// File: rtl/core/ptq_cell.sv
module ptq_cell (
    input  logic               i_clk,
    input  ptq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_ge_left,
    input  logic               i_ge_right,
    input  ptq_pkg::t_slot     i_left,
    input  ptq_pkg::t_slot     i_right,
    output ptq_pkg::t_slot     o_slot,
    output logic               o_ge
);
    import ptq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // A new entry goes behind every entry of lower or equal priority number, so
    // this cell lies at or past the insertion point when it is empty or
    // holds a strictly larger priority number.
    assign o_ge = !i_occupied || (r_slot.prio > i_ctl.new_slot.prio);

    always_comb begin
        n_slot = r_slot;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                n_slot = r_slot;
            end
            CELL_INSERT: begin
                if (i_ge_left) begin
                    n_slot = i_left;
                end else if (o_ge) begin
                    n_slot = i_ctl.new_slot;
                end
            end
            CELL_POP: begin
                n_slot = i_right;
            end
            CELL_INSERT_POP: begin
                // Insert and pop in one step: the queue after insertion,
                // moved one slot toward the head.
                if (!i_ge_right) begin
                    n_slot = i_right;
                end else if (!o_ge) begin
                    n_slot = i_ctl.new_slot;
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

// File: rtl/core/priority_task_queue.sv
// Channel   Direction  Transfer condition             Payload
// command   in         start && !busy at clock edge   i_cmd (mode, handle, priority)
// result    out        o_result_valid for one cycle   o_result (status, pop, count)
// config    in         psel && penable && pwrite      pwdata[9:0] -> idle_priority
//
// A command can be taken at every edge; the row of slot cells shifts all entries
// in parallel at the edge that takes the command.
// The result appears on the cycle after the command transfer and lasts one cycle.
// busy stays low; the receiver cannot stall, so no backpressure exists.
// Reset (synchronous, active low) empties the queue, clears the executing flag
// and sets idle and running priority to 999; slot contents are not cleared.
module priority_task_queue #(
    parameter int QUEUE_DEPTH = ptq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ptq_pkg::t_cmd                 i_cmd,
    output logic                          o_result_valid,
    output ptq_pkg::t_result              o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptq_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ptq_pkg::*;

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [PRIO_W-1:0]  r_running;
    logic [PRIO_W-1:0]  n_running;
    logic               r_exec;
    logic               n_exec;
    logic [PRIO_W-1:0]  r_idle;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;

    t_cell_ctl          cell_ctl;
    t_slot              w_slot [QUEUE_DEPTH];
    logic               w_ge   [QUEUE_DEPTH];

    logic               cmd_fire;
    logic               cfg_write;
    logic               full;
    logic               preempt;
    t_slot              popped;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign cmd_fire = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == REG_IDLE_PRIORITY);
    assign prdata   = (paddr == REG_IDLE_PRIORITY) ? {{(32-PRIO_W){1'b0}}, r_idle} : 32'd0;

    assign full    = (r_count >= COUNT_W'(QUEUE_DEPTH));
    assign preempt = r_exec && (i_cmd.task_priority < r_running);

    always_comb begin
        cell_ctl.new_slot.prio   = i_cmd.task_priority;
        cell_ctl.new_slot.handle = i_cmd.task_handle;
        cell_ctl.op = CELL_HOLD;
        if (cmd_fire) begin
            priority case (1'b1)
                (i_cmd.mode == MODE_ENQUEUE) && !full:
                    cell_ctl.op = preempt ? CELL_INSERT_POP : CELL_INSERT;
                (i_cmd.mode == MODE_DISPATCH) && (r_count != '0):
                    cell_ctl.op = CELL_POP;
                default:
                    cell_ctl.op = CELL_HOLD;
            endcase
        end
    end

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic  ge_left;
        logic  ge_right;
        t_slot left_slot;
        t_slot right_slot;

        if (gi == 0) begin : g_head
            assign ge_left   = 1'b0;
            assign left_slot = cell_ctl.new_slot;
        end else begin : g_mid_l
            assign ge_left   = w_ge[gi-1];
            assign left_slot = w_slot[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign ge_right   = 1'b1;
            assign right_slot = w_slot[gi];
        end else begin : g_mid_r
            assign ge_right   = w_ge[gi+1];
            assign right_slot = w_slot[gi+1];
        end

        ptq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_occupied (COUNT_W'(gi) < r_count),
            .i_ge_left  (ge_left),
            .i_ge_right (ge_right),
            .i_left     (left_slot),
            .i_right    (right_slot),
            .o_slot     (w_slot[gi]),
            .o_ge       (w_ge[gi])
        );
    end

    // With a preemption the popped entry is the head after insertion, which
    // is the new task only when it lands in front of every stored entry.
    assign popped = ((cell_ctl.op == CELL_INSERT_POP) && w_ge[0]) ? cell_ctl.new_slot
                                                                 : w_slot[0];

    always_comb begin
        n_count   = r_count;
        n_running = r_running;
        n_exec    = r_exec;

        n_out.status              = ST_OK;
        n_out.dispatch_valid      = 1'b0;
        n_out.dispatched_handle   = '0;
        n_out.dispatched_priority = '0;

        unique case (i_cmd.mode)
            MODE_ENQUEUE: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end
            end
            MODE_DISPATCH: begin
                n_exec = 1'b1;
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end
            end
            MODE_DONE: begin
                n_exec    = 1'b0;
                n_running = r_idle;
            end
            default: begin
                n_exec = r_exec;
            end
        endcase

        unique case (cell_ctl.op)
            CELL_INSERT:     n_count = r_count + 1'b1;
            CELL_POP:        n_count = r_count - 1'b1;
            CELL_INSERT_POP: n_count = r_count;
            default:         n_count = r_count;
        endcase

        if ((cell_ctl.op == CELL_POP) || (cell_ctl.op == CELL_INSERT_POP)) begin
            n_running                 = popped.prio;
            n_out.dispatch_valid      = 1'b1;
            n_out.dispatched_handle   = popped.handle;
            n_out.dispatched_priority = popped.prio;
        end

        n_out.queue_count = COUNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_running   <= RESET_IDLE_PRIORITY;
            r_exec      <= 1'b0;
            r_idle      <= RESET_IDLE_PRIORITY;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= cmd_fire;
            if (cmd_fire) begin
                r_count   <= n_count;
                r_running <= n_running;
                r_exec    <= n_exec;
            end
            if (cfg_write) begin
                r_idle <= pwdata[PRIO_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_out <= n_out;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// File: test/priority_task_queue_tb.sv
module priority_task_queue_tb;
    import ptq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 425;
    localparam int PRINT_CAP = 50;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_cmd               i_cmd = '0;
    logic               o_result_valid;
    t_result            o_result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow copy of the scheduler state, advanced once per accepted command.
    logic [PRIO_W-1:0]   shadow_prio [DEPTH];
    logic [HANDLE_W-1:0] shadow_handle [DEPTH];
    int                  shadow_count = 0;
    logic [PRIO_W-1:0]   shadow_running_prio = RESET_IDLE_PRIORITY;
    logic                shadow_executing = 1'b0;
    logic [PRIO_W-1:0]   shadow_idle_prio = RESET_IDLE_PRIORITY;

    t_result pending_results[$];

    int mismatch_count = 0;
    int cmd_count = 0;
    int result_count = 0;
    int preempt_count = 0;
    int full_count = 0;
    int empty_count = 0;
    int stall_cycles = 0;
    int sender_idle_pct = 0;

    priority_task_queue u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        // Keep the log readable when a defect hits every result.
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                     what, got, want, result_count);
        end
        mismatch_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic void shadow_pop_head(inout t_result r);
        int i;
        r.dispatch_valid = 1'b1;
        r.dispatched_handle = shadow_handle[0];
        r.dispatched_priority = shadow_prio[0];
        for (i = 1; i < shadow_count; i++) begin
            shadow_handle[i-1] = shadow_handle[i];
            shadow_prio[i-1] = shadow_prio[i];
        end
        shadow_count--;
        shadow_running_prio = r.dispatched_priority;
    endfunction

    function automatic t_result schedule_step(t_cmd cmd);
        t_result r;
        int pos;
        int i;
        r = '0;
        r.status = ST_OK;
        case (cmd.mode)
            MODE_ENQUEUE: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // Equal priorities go behind the ones already queued.
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= cmd.task_priority) begin
                        pos++;
                    end
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_handle[i] = shadow_handle[i-1];
                        shadow_prio[i] = shadow_prio[i-1];
                    end
                    shadow_handle[pos] = cmd.task_handle;
                    shadow_prio[pos] = cmd.task_priority;
                    shadow_count++;
                    if (shadow_executing && cmd.task_priority < shadow_running_prio) begin
                        shadow_pop_head(r);
                    end
                end
            end
            MODE_DISPATCH: begin
                shadow_executing = 1'b1;
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_pop_head(r);
                end
            end
            MODE_DONE: begin
                shadow_executing = 1'b0;
                shadow_running_prio = shadow_idle_prio;
            end
            default: begin
            end
        endcase
        r.queue_count = COUNT_OUT_W'(shadow_count);
        return r;
    endfunction

    function automatic t_cmd make_cmd(logic [1:0] mode, int handle, int prio);
        t_cmd c;
        c.mode = mode;
        c.task_handle = HANDLE_W'(handle);
        c.task_priority = PRIO_W'(prio);
        return c;
    endfunction

    task automatic push_command(t_cmd cmd);
        t_result want;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        want = schedule_step(cmd);
        pending_results.push_back(want);
        cmd_count++;
        if (cmd.mode == MODE_ENQUEUE && want.dispatch_valid) preempt_count++;
        if (want.status == ST_FULL) full_count++;
        if (want.status == ST_EMPTY) empty_count++;
    endtask

    // Every command yields a result, so once nothing is pending the block is idle.
    task automatic wait_queue_settled();
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
    endtask

    // Write the register, then read it back in the following transfer.
    task automatic program_idle_priority(logic [PRIO_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_IDLE_PRIORITY;
        pwdata <= {22'($urandom_range(0, 32'h3F_FFFF)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        shadow_idle_prio = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        check_field("idle_priority readback", 32'(prdata[PRIO_W-1:0]), 32'(value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_register_access();
        program_idle_priority(RESET_IDLE_PRIORITY);
    endtask

    task automatic test_empty_queue();
        push_command(make_cmd(MODE_DISPATCH, 0, 0));
        push_command(make_cmd(MODE_DONE, 0, 0));
        push_command(make_cmd(MODE_DONE, 0, 0));
        push_command(make_cmd(MODE_UNUSED, 255, 1023));
        wait_queue_settled();
    endtask

    task automatic test_preemption();
        // An empty dispatch starts execution at the idle priority.
        push_command(make_cmd(MODE_DISPATCH, 0, 0));
        push_command(make_cmd(MODE_ENQUEUE, 1, 1000));
        push_command(make_cmd(MODE_ENQUEUE, 2, 5));
        push_command(make_cmd(MODE_ENQUEUE, 3, 5));
        push_command(make_cmd(MODE_DISPATCH, 0, 0));
        wait_queue_settled();
    endtask

    task automatic test_full_queue();
        int prio_list[15] = '{1023, 0, 512, 0, 1023, 7, 7, 7, 300, 0, 1, 1022, 512, 256, 1023};
        int i;
        push_command(make_cmd(MODE_DONE, 0, 0));
        for (i = 0; i < 15; i++) begin
            push_command(make_cmd(MODE_ENQUEUE, i * 17, prio_list[i]));
        end
        push_command(make_cmd(MODE_ENQUEUE, 255, 0));
        push_command(make_cmd(MODE_DISPATCH, 0, 0));
        push_command(make_cmd(MODE_ENQUEUE, 255, 1023));
        // Full while executing: dropped, with no preemption (its priority 0 equals the running one).
        push_command(make_cmd(MODE_ENQUEUE, 254, 0));
        push_command(make_cmd(MODE_DONE, 0, 0));
        wait_queue_settled();
    endtask

    task automatic test_random_traffic(int items, int idle_pct);
        int n;
        int burst;
        int enq_pct;
        int sel;
        int kind;
        t_cmd cmd;
        sender_idle_pct = idle_pct;
        burst = 0;
        enq_pct = 50;
        for (n = 0; n < items; n++) begin
            // Bursts lean toward filling or draining so that both ends are reached.
            if (burst == 0) begin
                burst = $urandom_range(6, 40);
                case ($urandom_range(0, 2))
                    0: enq_pct = 85;
                    1: enq_pct = 55;
                    default: enq_pct = 30;
                endcase
            end
            burst--;
            cmd.task_handle = HANDLE_W'($urandom_range(0, 255));
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                cmd.task_priority = PRIO_W'($urandom_range(0, 7));
            end else if (kind == 4) begin
                cmd.task_priority = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                cmd.task_priority = PRIO_W'($urandom_range(0, 1023));
            end
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                cmd.mode = MODE_UNUSED;
            end else if (sel < 3 + enq_pct) begin
                cmd.mode = MODE_ENQUEUE;
            end else if ($urandom_range(0, 3) != 0) begin
                cmd.mode = MODE_DISPATCH;
            end else begin
                cmd.mode = MODE_DONE;
            end
            push_command(cmd);
            if ($urandom_range(0, 299) == 0) begin
                wait_queue_settled();
            end
        end
        wait_queue_settled();
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_result), 0);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(o_result.status), 32'(want.status));
                check_field("dispatch_valid", 32'(o_result.dispatch_valid),
                            32'(want.dispatch_valid));
                check_field("dispatched_handle", 32'(o_result.dispatched_handle),
                            32'(want.dispatched_handle));
                check_field("dispatched_priority", 32'(o_result.dispatched_priority),
                            32'(want.dispatched_priority));
                check_field("queue_count", 32'(o_result.queue_count),
                            32'(want.queue_count));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_empty_queue();
        test_preemption();
        test_full_queue();

        program_idle_priority('0);
        test_random_traffic(PHASE_ITEMS, 0);
        program_idle_priority('1);
        test_random_traffic(PHASE_ITEMS, 87);
        program_idle_priority(PRIO_W'($urandom_range(0, 1023)));
        test_random_traffic(PHASE_ITEMS, 0);
        program_idle_priority(RESET_IDLE_PRIORITY);
        test_random_traffic(PHASE_ITEMS, 30);

        wait_queue_settled();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d commands and %0d results: %0d preemptions, %0d full drops,",
                 cmd_count, result_count, preempt_count, full_count);
        $display("%0d empty dispatches, idle priority at 0, 1023, 999 and a random value.",
                 empty_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/ptq_pkg.sv
rtl/core/ptq_cell.sv
rtl/core/priority_task_queue.sv
test/priority_task_queue_tb.sv
